### design/dtcb_pkg.sv
// Shared types and constants for the decimating trace capture buffer.
package dtcb_pkg;

  localparam int DEPTH      = 256;
  localparam int ADDR_W     = 8;
  localparam int ROW_W      = 9;
  localparam int SAMPLE_W   = 16;
  localparam int CHANNELS   = 4;
  localparam int ROW_DATA_W = SAMPLE_W * CHANNELS;
  localparam int CH_W       = 2;
  localparam int TAG_W      = 8;
  localparam int DEC_W      = 16;
  localparam int COUNT_W    = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;

  localparam logic [ROW_W-1:0] DEPTH_ROWS = ROW_W'(DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_ARM  = 2'd1,
    CMD_STOP = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RING = 2'd1,
    MODE_ONCE = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_TAG   = 2'd2;

  // Result of one request, waiting on the store read.
  typedef struct packed {
    logic               is_read;
    logic [CH_W-1:0]    channel;
    logic [ROW_W-1:0]   write_index;
    logic               wrapped;
    mode_t              active_mode;
    logic [COUNT_W-1:0] push_count;
    logic [TAG_W-1:0]   tag;
  } pend_t;

endpackage

### design/dtcb_sample_ram.sv
// Sample store: one write port, one read port, registered read data.
module dtcb_sample_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [dtcb_pkg::ADDR_W-1:0]     waddr,
  input  logic [dtcb_pkg::ROW_DATA_W-1:0] wdata,
  input  logic                           re,
  input  logic [dtcb_pkg::ADDR_W-1:0]     raddr,
  output logic [dtcb_pkg::ROW_DATA_W-1:0] rdata
);
  import dtcb_pkg::*;

  logic [ROW_DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read row until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/decimating_trace_capture_buffer.sv
// Top level of the decimating four-channel trace capture buffer.
//
// Usage:
//   The cfg channel writes capture_mode (index 0), decimation (index 1) and
//   source_tag (index 2); it is always ready. Write it only while idle.
//   Requests enter on the s_* stream: s_tuser carries the command (push,
//   arm, stop, read), s_tdata the four samples and the read address.
//   Every request yields exactly one result on the m_* stream: the read
//   sample (zero for non-read commands) plus the capture status after the
//   request (write index, wrap flag, mode, push count, latched tag).
// Pipeline and throughput:
//   The store read and the status capture happen when a request is
//   accepted; the output register loads from the pending stage when that
//   stage advances. One request per cycle is sustained while m_tready is
//   high; counters live in flops and the store takes one row write per push,
//   so only backpressure limits back-to-back flow.
// Reset:
//   Synchronous rst idles capture, clears index, counters and wrap flag,
//   sets decimation to one and empties the pipeline; store contents are not
//   cleared. Read rows only after a push has written them; block won't check.
// Backpressure:
//   When m_tready is low the output and pending stage hold and s_tready
//   drops once both are full; no result is lost or repeated.
module decimating_trace_capture_buffer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtcb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] sample0, [31:16] sample1, [47:32] sample2, [63:48] sample3,
  // [71:64] read_row, [73:72] read_channel, [79:74] zero
  input  logic [dtcb_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] cmd
  input  logic [dtcb_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] read_data, [24:16] write_index, [25] wrapped, [27:26] active_mode,
  // [59:28] push_count, [67:60] tag, [71:68] zero
  output logic [dtcb_pkg::OUT_DATA_W-1:0] m_tdata
);
  import dtcb_pkg::*;

  // Configuration registers.
  logic [1:0]       capture_mode;
  logic [DEC_W-1:0] decimation;
  logic [TAG_W-1:0] source_tag;

  // Capture state.
  mode_t              mode_now, mode_next;
  logic [ROW_W-1:0]   next_row, next_row_next;
  logic [DEC_W-1:0]   skip_count, skip_count_next;
  logic [COUNT_W-1:0] pushes_seen, pushes_seen_next;
  logic               wrap_flag, wrap_flag_next;
  logic [TAG_W-1:0]   latched_tag, latched_tag_next;
  logic [DEC_W-1:0]   latched_decimation, latched_decimation_next;

  logic             in_accept;
  cmd_t             cmd;
  logic [DEC_W-1:0] skip_inc;
  logic [ROW_W-1:0] row_inc;
  logic             store_ok;
  logic             mem_we;
  logic             mem_re;
  logic [ROW_DATA_W-1:0] rd_row;

  // Pending stage and output register.
  logic  pend_valid;
  pend_t pend;
  logic  pend_advance;
  logic [SAMPLE_W-1:0] read_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_mode <= '0;
      decimation   <= DEC_W'(1);
      source_tag   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAPTURE_MODE: capture_mode <= cfg_data[1:0];
        CFG_DECIMATION:   decimation   <= cfg_data[DEC_W-1:0];
        CFG_SOURCE_TAG:   source_tag   <= cfg_data[TAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept while the pending stage is free or moving into the output.
  assign pend_advance = pend_valid && (!m_tvalid || m_tready);
  assign s_tready     = !pend_valid || !m_tvalid || m_tready;
  assign in_accept    = s_tvalid && s_tready;
  assign cmd          = cmd_t'(s_tuser[1:0]);

  assign skip_inc = skip_count + DEC_W'(1);
  assign row_inc  = next_row + ROW_W'(1);

  always_comb begin
    mode_next               = mode_now;
    next_row_next           = next_row;
    skip_count_next         = skip_count;
    pushes_seen_next        = pushes_seen;
    wrap_flag_next          = wrap_flag;
    latched_tag_next        = latched_tag;
    latched_decimation_next = latched_decimation;
    store_ok                = 1'b0;
    mem_we                  = 1'b0;
    if (in_accept) begin
      unique case (cmd)
        CMD_PUSH: begin
          if (mode_now != MODE_IDLE) begin
            pushes_seen_next = pushes_seen + COUNT_W'(1);
            store_ok         = 1'b1;
            if (latched_decimation > DEC_W'(1)) begin
              if (skip_inc < latched_decimation) begin
                skip_count_next = skip_inc;
                store_ok        = 1'b0;
              end else begin
                skip_count_next = '0;
              end
            end
            if (store_ok && (next_row < DEPTH_ROWS)) begin
              mem_we = 1'b1;
              if (row_inc == DEPTH_ROWS) begin
                wrap_flag_next = 1'b1;
                if (mode_now == MODE_ONCE) begin
                  // Park at the end and stop.
                  next_row_next = DEPTH_ROWS;
                  mode_next     = MODE_IDLE;
                end else begin
                  next_row_next = '0;
                end
              end else begin
                next_row_next = row_inc;
              end
            end
          end
        end
        CMD_ARM: begin
          next_row_next           = '0;
          skip_count_next         = '0;
          pushes_seen_next        = '0;
          wrap_flag_next          = 1'b0;
          latched_decimation_next = decimation;
          latched_tag_next        = source_tag;
          // Reserved mode arms as idle.
          if (capture_mode == MODE_RING || capture_mode == MODE_ONCE) begin
            mode_next = mode_t'(capture_mode);
          end else begin
            mode_next = MODE_IDLE;
          end
        end
        CMD_STOP: mode_next = MODE_IDLE;
        CMD_READ: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_now           <= MODE_IDLE;
      next_row           <= '0;
      skip_count         <= '0;
      pushes_seen        <= '0;
      wrap_flag          <= 1'b0;
      latched_tag        <= '0;
      latched_decimation <= DEC_W'(1);
    end else begin
      mode_now           <= mode_next;
      next_row           <= next_row_next;
      skip_count         <= skip_count_next;
      pushes_seen        <= pushes_seen_next;
      wrap_flag          <= wrap_flag_next;
      latched_tag        <= latched_tag_next;
      latched_decimation <= latched_decimation_next;
    end
  end

  // One request per edge, so a write and a read never hit the store at the
  // same edge; a read right after a push sees the new row.
  assign mem_re = in_accept && (cmd == CMD_READ);

  dtcb_sample_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (next_row[ADDR_W-1:0]),
    .wdata (s_tdata[ROW_DATA_W-1:0]),
    .re    (mem_re),
    .raddr (s_tdata[ROW_DATA_W +: ADDR_W]),
    .rdata (rd_row)
  );

  // Capture the post-request status while the store read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_accept) begin
      pend_valid <= 1'b1;
    end else if (pend_advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend.is_read     <= (cmd == CMD_READ);
      pend.channel     <= s_tdata[ROW_DATA_W + ADDR_W +: CH_W];
      pend.write_index <= next_row_next;
      pend.wrapped     <= wrap_flag_next;
      pend.active_mode <= mode_next;
      pend.push_count  <= pushes_seen_next;
      pend.tag         <= latched_tag_next;
    end
  end

  assign read_data = pend.is_read ? rd_row[SAMPLE_W*pend.channel +: SAMPLE_W]
                                  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pend_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_advance) begin
      m_tdata <= {4'b0000, pend.tag, pend.push_count, pend.active_mode,
                  pend.wrapped, pend.write_index, read_data};
    end
  end

`ifndef NO_ASSERTIONS
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    next_row <= DEPTH_ROWS)
    else $error("write index beyond store depth");

  a_ring_in_range: assert property (@(posedge clk) disable iff (rst)
    (mode_now == MODE_RING) |-> (next_row < DEPTH_ROWS))
    else $error("continuous capture with parked index");

  a_write_when_capturing: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mode_now != MODE_IDLE && cmd == CMD_PUSH))
    else $error("store written outside capture");

  a_arm_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd == CMD_ARM) |=> (next_row == '0 && pushes_seen == '0 &&
                                       !wrap_flag && skip_count == '0))
    else $error("arm did not clear capture state");

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_advance) |=> (pend_valid && $stable(pend)))
    else $error("pending result lost under stall");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the trace capture buffer: directed plan, then random capture phases.
module testbench;
  import dtcb_pkg::*;

  // One request on the input stream.
  typedef struct packed {
    cmd_t                  cmd;
    logic [ROW_DATA_W-1:0] samples;  // {sample3, sample2, sample1, sample0}
    logic [ADDR_W-1:0]     rrow;
    logic [CH_W-1:0]       rch;
  } req_t;

  // Capture status returned with every request.
  typedef struct packed {
    logic [SAMPLE_W-1:0] read_data;
    logic [ROW_W-1:0]    write_index;
    logic                wrapped;
    mode_t               active_mode;
    logic [COUNT_W-1:0]  push_count;
    logic [TAG_W-1:0]    tag;
  } status_t;

  // One line of the directed plan: either a register write or a request.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    req_t                  req;
    bit                    typed;
    status_t               want;
  } plan_row_t;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int ITEM_TARGET = 1450;
  localparam int MAX_GAP     = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  decimating_trace_capture_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Capture predictor: host-side register copies, live capture state and a
  // shadow of the sample store. Advanced once per accepted request.
  // ---------------------------------------------------------------------------
  logic [1:0]          reg_mode = 2'd0;
  logic [DEC_W-1:0]    reg_dec  = 16'd1;
  logic [TAG_W-1:0]    reg_tag  = '0;

  mode_t               cap_mode   = MODE_IDLE;
  logic [ROW_W-1:0]    cap_row    = '0;
  logic [DEC_W-1:0]    cap_skip   = '0;
  logic [COUNT_W-1:0]  cap_pushes = '0;
  logic                cap_wrap   = 1'b0;
  logic [TAG_W-1:0]    cap_tag    = '0;
  logic [DEC_W-1:0]    cap_dec    = 16'd1;

  logic [ROW_DATA_W-1:0] trace_rows [DEPTH];
  bit                    row_written [DEPTH];
  int                    written_list [$];  // rows safe to read back

  status_t   status_due [$];  // expected status per accepted request, oldest first
  plan_row_t directed_plan [$];

  int mismatches    = 0;
  int accepted_reqs = 0;
  int results_seen  = 0;

  function automatic status_t capture_step(input req_t r);
    status_t          s;
    logic [DEC_W-1:0] next_skip;
    logic [ROW_W-1:0] row;
    bit               keep;
    s = '0;
    case (r.cmd)
      CMD_PUSH: begin
        // Pushes only count while a capture is running.
        if (cap_mode != MODE_IDLE) begin
          cap_pushes = cap_pushes + 1'b1;
          keep = 1'b1;
          if (cap_dec > 16'd1) begin
            next_skip = cap_skip + 1'b1;
            if (next_skip < cap_dec) begin
              cap_skip = next_skip;
              keep = 1'b0;
            end else begin
              cap_skip = '0;
            end
          end
          if (keep && cap_row < DEPTH_ROWS) begin
            row = cap_row;
            trace_rows[row[ADDR_W-1:0]] = r.samples;
            if (!row_written[row[ADDR_W-1:0]]) begin
              row_written[row[ADDR_W-1:0]] = 1'b1;
              written_list.push_back(int'(row));
            end
            if (row == DEPTH_ROWS - 1'b1) begin
              // Store full: ring wraps to row zero, one-shot parks and idles.
              cap_wrap = 1'b1;
              if (cap_mode == MODE_ONCE) begin
                cap_row  = DEPTH_ROWS;
                cap_mode = MODE_IDLE;
              end else begin
                cap_row = '0;
              end
            end else begin
              cap_row = row + 1'b1;
            end
          end
        end
      end
      CMD_ARM: begin
        cap_row    = '0;
        cap_skip   = '0;
        cap_pushes = '0;
        cap_wrap   = 1'b0;
        cap_dec    = reg_dec;
        cap_tag    = reg_tag;
        // Reserved mode arms as idle, counters still clear.
        if (reg_mode == MODE_RING || reg_mode == MODE_ONCE) begin
          cap_mode = mode_t'(reg_mode);
        end else begin
          cap_mode = MODE_IDLE;
        end
      end
      CMD_STOP: begin
        cap_mode = MODE_IDLE;
      end
      CMD_READ: begin
        s.read_data = trace_rows[r.rrow][r.rch*SAMPLE_W +: SAMPLE_W];
      end
    endcase
    s.write_index = cap_row;
    s.wrapped     = cap_wrap;
    s.active_mode = cap_mode;
    s.push_count  = cap_pushes;
    s.tag         = cap_tag;
    return s;
  endfunction

  function automatic status_t st(input logic [SAMPLE_W-1:0] data, input logic [ROW_W-1:0] idx,
                                 input logic wrap, input mode_t mode,
                                 input logic [COUNT_W-1:0] count, input logic [TAG_W-1:0] tag);
    status_t s;
    s.read_data   = data;
    s.write_index = idx;
    s.wrapped     = wrap;
    s.active_mode = mode;
    s.push_count  = count;
    s.tag         = tag;
    return s;
  endfunction

  function automatic void add_req(input cmd_t c, input logic [ROW_DATA_W-1:0] smp,
                                  input logic [ADDR_W-1:0] rw, input logic [CH_W-1:0] ch,
                                  input bit typed, input status_t want);
    plan_row_t p;
    p.is_cfg      = 1'b0;
    p.cfg_idx     = '0;
    p.cfg_val     = '0;
    p.req.cmd     = c;
    p.req.samples = smp;
    p.req.rrow    = rw;
    p.req.rch     = ch;
    p.typed       = typed;
    p.want        = want;
    directed_plan.push_back(p);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    plan_row_t p;
    p        = '{default: '0};
    p.is_cfg  = 1'b1;
    p.cfg_idx = idx;
    p.cfg_val = val;
    directed_plan.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap; hold it until the block takes it.
  // Valid stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_request(input req_t r, input bit typed, input status_t want);
    int      gap;
    status_t due;
    // Every fourth stretch of 100 requests goes out with no gaps.
    gap = (((accepted_reqs / 100) % 4) == 1) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.rch, r.rrow, r.samples};
    s_tuser  <= r.cmd;
    do @(posedge clk); while (!s_tready);
    due = capture_step(r);
    status_due.push_back(typed ? want : due);
    accepted_reqs++;
  endtask

  // Drop valid and wait until every outstanding result is back and the
  // two-stage pipeline has emptied, so registers may be rewritten.
  task automatic drain_requests();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAPTURE_MODE: reg_mode = val[1:0];
      CFG_DECIMATION:   reg_dec  = val;
      CFG_SOURCE_TAG:   reg_tag  = val[TAG_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    plan_row_t             p;
    req_t                  rq;
    bit                    in_config;
    bit                    ignored;
    int                    random_items;
    int                    budget;
    int                    counted;
    int                    pick;
    logic [CFG_DATA_W-1:0] mode_val;
    logic [CFG_DATA_W-1:0] dec_val;

    // Directed plan. Expected status is typed in where it is obvious.
    // Commands on a fresh block, push while idle, arm with the reset mode.
    add_req(CMD_STOP, '0, '0, 2'd1, 1, st('0, '0, 1'b0, MODE_IDLE, '0, '0));
    add_req(CMD_PUSH, 64'h8000_7FFF_FFFF_0000, 8'hFF, 2'd3, 1,
            st('0, '0, 1'b0, MODE_IDLE, '0, '0));
    add_req(CMD_ARM, '0, '0, 2'd0, 1, st('0, '0, 1'b0, MODE_IDLE, '0, '0));
    // Reserved mode arms as idle but still latches the tag.
    add_cfg(CFG_CAPTURE_MODE, CFG_DATA_W'(MODE_RESERVED));
    add_cfg(CFG_SOURCE_TAG, 16'h00FF);
    add_req(CMD_ARM, '0, '0, 2'd0, 1, st('0, '0, 1'b0, MODE_IDLE, '0, 8'hFF));
    // Ring capture, decimation zero stores every push.
    add_cfg(CFG_CAPTURE_MODE, CFG_DATA_W'(MODE_RING));
    add_cfg(CFG_DECIMATION, 16'h0000);
    add_req(CMD_ARM, '0, '0, 2'd0, 1, st('0, '0, 1'b0, MODE_RING, '0, 8'hFF));
    add_req(CMD_PUSH, {4{16'h8000}}, '0, 2'd0, 1, st('0, 9'd1, 1'b0, MODE_RING, 32'd1, 8'hFF));
    add_req(CMD_PUSH, {4{16'h7FFF}}, '0, 2'd0, 1, st('0, 9'd2, 1'b0, MODE_RING, 32'd2, 8'hFF));
    add_req(CMD_PUSH, 64'hAAAA_5555_0000_FFFF, '0, 2'd0, 1,
            st('0, 9'd3, 1'b0, MODE_RING, 32'd3, 8'hFF));
    add_req(CMD_READ, '0, 8'd0, 2'd0, 1, st(16'h8000, 9'd3, 1'b0, MODE_RING, 32'd3, 8'hFF));
    add_req(CMD_READ, '0, 8'd1, 2'd3, 1, st(16'h7FFF, 9'd3, 1'b0, MODE_RING, 32'd3, 8'hFF));
    add_req(CMD_READ, '0, 8'd2, 2'd2, 1, st(16'h5555, 9'd3, 1'b0, MODE_RING, 32'd3, 8'hFF));
    add_req(CMD_STOP, '0, '0, 2'd0, 1, st('0, 9'd3, 1'b0, MODE_IDLE, 32'd3, 8'hFF));
    add_req(CMD_PUSH, {$urandom, $urandom}, '0, 2'd0, 1,
            st('0, 9'd3, 1'b0, MODE_IDLE, 32'd3, 8'hFF));
    // One-shot at the largest decimation: pushes count but nothing is stored.
    add_cfg(CFG_DECIMATION, 16'hFFFF);
    add_cfg(CFG_CAPTURE_MODE, CFG_DATA_W'(MODE_ONCE));
    add_cfg(CFG_SOURCE_TAG, 16'h005A);
    add_req(CMD_ARM, '0, '0, 2'd0, 1, st('0, '0, 1'b0, MODE_ONCE, '0, 8'h5A));
    add_req(CMD_PUSH, {$urandom, $urandom}, '0, 2'd0, 0, '0);
    add_req(CMD_PUSH, {$urandom, $urandom}, '0, 2'd0, 0, '0);
    add_req(CMD_READ, '0, 8'd2, 2'd1, 1, st('0, '0, 1'b0, MODE_ONCE, 32'd2, 8'h5A));
    add_req(CMD_READ, '0, 8'd2, 2'd3, 1, st(16'hAAAA, '0, 1'b0, MODE_ONCE, 32'd2, 8'h5A));
    add_req(CMD_STOP, '0, '0, 2'd0, 0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed plan; drain before each group of register writes.
    in_config = 1'b0;
    foreach (directed_plan[i]) begin
      p = directed_plan[i];
      if (p.is_cfg) begin
        if (!in_config) begin
          drain_requests();
          in_config = 1'b1;
        end
        write_register(p.cfg_idx, p.cfg_val);
      end else begin
        if (in_config) begin
          cfg_valid <= 1'b0;
          in_config = 1'b0;
        end
        send_request(p.req, p.typed, p.want);
      end
    end

    // Random capture phases. Each one reprograms all registers while idle,
    // arms, then runs mostly pushes with reads of rows already written.
    // Pushes that land while idle are noise and do not advance the count.
    random_items = 0;
    while (random_items < ITEM_TARGET) begin
      budget = $urandom_range(150, 350);
      if (budget > ITEM_TARGET - random_items) budget = ITEM_TARGET - random_items;

      pick = $urandom_range(0, 99);
      if (pick < 5)       mode_val = CFG_DATA_W'(MODE_IDLE);
      else if (pick < 10) mode_val = CFG_DATA_W'(MODE_RESERVED);
      else if (pick < 55) mode_val = CFG_DATA_W'(MODE_RING);
      else                mode_val = CFG_DATA_W'(MODE_ONCE);
      // Mostly small decimation so the store fills and wraps within a phase.
      pick = $urandom_range(0, 99);
      if (pick < 20)      dec_val = 16'd0;
      else if (pick < 50) dec_val = 16'd1;
      else if (pick < 75) dec_val = 16'd2;
      else if (pick < 95) dec_val = CFG_DATA_W'($urandom_range(3, 7));
      else                dec_val = 16'hFFFF;

      drain_requests();
      write_register(CFG_CAPTURE_MODE, mode_val);
      write_register(CFG_DECIMATION, dec_val);
      write_register(CFG_SOURCE_TAG, CFG_DATA_W'($urandom_range(0, 255)));
      cfg_valid <= 1'b0;

      rq = '0;
      rq.cmd = CMD_ARM;
      send_request(rq, 1'b0, '0);

      counted = 0;
      while (counted < budget) begin
        rq.samples = {$urandom, $urandom};
        rq.rrow    = ADDR_W'($urandom_range(0, 255));
        rq.rch     = CH_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (cap_mode == MODE_IDLE) begin
          // Idle: rearm often, otherwise read back or poke.
          if (pick < 40)      rq.cmd = CMD_ARM;
          else if (pick < 70) rq.cmd = CMD_READ;
          else if (pick < 95) rq.cmd = CMD_PUSH;
          else                rq.cmd = CMD_STOP;
        end else begin
          if (pick < 2)       rq.cmd = CMD_ARM;
          else if (pick < 4)  rq.cmd = CMD_STOP;
          else if (pick < 24) rq.cmd = CMD_READ;
          else                rq.cmd = CMD_PUSH;
        end
        // Never read a row that has not been written since reset.
        if (rq.cmd == CMD_READ) begin
          if (written_list.size() == 0) begin
            rq.cmd = CMD_PUSH;
          end else begin
            rq.rrow = ADDR_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
          end
        end
        ignored = (rq.cmd == CMD_PUSH) && (cap_mode == MODE_IDLE);
        send_request(rq, 1'b0, '0);
        if (!ignored) counted++;
      end
      random_items += counted;
    end

    drain_requests();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls after each result, one long hold-off while the
  // sender keeps offering so the block backs up and drops s_tready, and
  // field-by-field compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  int      stall_left = 0;
  int      hold_left  = 0;
  bit      hold_done  = 1'b0;
  status_t got;
  status_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.read_data   = m_tdata[15:0];
        got.write_index = m_tdata[24:16];
        got.wrapped     = m_tdata[25];
        got.active_mode = mode_t'(m_tdata[27:26]);
        got.push_count  = m_tdata[59:28];
        got.tag         = m_tdata[67:60];
        if (status_due.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            mismatches++;
          end
          if (got.write_index !== want.write_index) begin
            $error("write_index: expected %0d, got %0d", want.write_index, got.write_index);
            mismatches++;
          end
          if (got.wrapped !== want.wrapped) begin
            $error("wrapped: expected %0d, got %0d", want.wrapped, got.wrapped);
            mismatches++;
          end
          if (got.active_mode !== want.active_mode) begin
            $error("active_mode: expected %0d, got %0d", want.active_mode, got.active_mode);
            mismatches++;
          end
          if (got.push_count !== want.push_count) begin
            $error("push_count: expected %0d, got %0d", want.push_count, got.push_count);
            mismatches++;
          end
          if (got.tag !== want.tag) begin
            $error("tag: expected %h, got %h", want.tag, got.tag);
            mismatches++;
          end
        end
        results_seen++;
        // Every fourth stretch of 100 results is taken without stalls.
        stall_left = (((results_seen / 100) % 4) == 3) ? 0 : $urandom_range(0, MAX_GAP);
      end
      // Start the long hold-off once, while requests are still being offered.
      if (!hold_done && results_seen >= HOLD_AFTER && s_tvalid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

endmodule
